FILE: rtl/wges_pkg.sv
package wges_pkg;

    localparam int GRID_SIDE_DEF = 64;
    localparam int GAIN_W = 18;
    localparam int DAMP_W = 16;
    localparam int CFG_W = 18;
    localparam int VAL_W = 32;
    localparam int POS_W = 6;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd5898;
    localparam logic [DAMP_W-1:0] DAMP_RESET = 16'd32735;

    localparam logic CFG_GAIN = 1'b0;
    localparam logic CFG_DAMP = 1'b1;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_STEP = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    localparam logic [1:0] ST_WRITE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;
    localparam logic [1:0] ST_BAD = 2'd3;

endpackage

FILE: rtl/wave_grid_explicit_step.sv
// Wave grid explicit step: a GRID_SIDE x GRID_SIDE grid of Q16.16 heights and its
// previous time level, held in two synchronous memories. A write word answers in
// the cycle after it is accepted, a read word after the S_RD state; a step word sweeps
// rows 0 to GRID_SIDE-2 in raster order through states S_A and S_B for each border
// cell, adding S_C, S_M1, S_M2 and S_WB for each interior cell, because the
// current-height memory has one read port and each interior cell needs its center,
// south and east neighbors from it (north comes from a one-row line memory of old
// values, west from a register). After reset a clearing pass zeroes both grids
// before the first word is accepted; configuration writes are taken at any time.
module wave_grid_explicit_step
    #(
        parameter int GRID_SIDE = wges_pkg::GRID_SIDE_DEF
    )
    (
        input  logic                       clk,
        input  logic                       rst_n,
        input  logic                       cfg_we,
        input  logic                       cfg_index,
        input  logic [wges_pkg::CFG_W-1:0] cfg_data,
        input  logic                       s_tvalid,
        output logic                       s_tready,
        // Fields from bit 0: row[5:0], col[11:6], cell_value[43:12].
        input  logic [47:0]                s_tdata,
        // Fields from bit 0: cmd[1:0].
        input  logic [1:0]                 s_tuser,
        output logic                       m_tvalid,
        input  logic                       m_tready,
        // Fields from bit 0: read_value[31:0].
        output logic [31:0]                m_tdata,
        // Fields from bit 0: status[1:0].
        output logic [1:0]                 m_tuser
    );

    import wges_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW = $clog2(CELLS);
    localparam int CW = $clog2(GRID_SIDE);
    localparam logic [CW-1:0] LAST_COL = CW'(GRID_SIDE - 1);
    localparam logic [CW-1:0] LAST_ROW = CW'(GRID_SIDE - 2);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_STEP = AW'(GRID_SIDE);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_A, S_B, S_C, S_M1, S_M2, S_WB
    } state_t;

    state_t state_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [DAMP_W-1:0] damp_reg;
    logic [AW-1:0] k_reg;
    logic [CW-1:0] r_reg;
    logic [CW-1:0] c_reg;
    logic rd_inside_reg;
    logic signed [VAL_W-1:0] center_reg, prevv_reg, north_reg, south_reg, west_reg;
    logic signed [53:0] p1_reg;
    logic signed [56:0] p2_reg;
    logic out_valid_reg;
    logic [1:0] out_status_reg;
    logic [VAL_W-1:0] out_value_reg;

    logic [VAL_W-1:0] cur_mem [CELLS];
    logic [VAL_W-1:0] prev_mem [CELLS];
    logic [VAL_W-1:0] line_mem [GRID_SIDE];
    logic [VAL_W-1:0] cur_rdata, prev_rdata, line_rdata;

    logic [AW-1:0] cur_raddr, cur_waddr, in_addr;
    logic cur_we, prev_we, line_we;
    logic [VAL_W-1:0] cur_wdata, prev_wdata, line_wdata;

    logic [POS_W-1:0] in_row, in_col;
    logic in_inside, accept, interior, last_cell, out_load;
    logic signed [35:0] lap;
    logic signed [37:0] s_val;
    logic signed [39:0] t_val;
    logic signed [41:0] n_val;
    logic signed [VAL_W-1:0] sat_val, east_val;

    assign in_row = s_tdata[5:0];
    assign in_col = s_tdata[11:6];
    assign in_inside = (32'(in_row) < 32'(GRID_SIDE)) && (32'(in_col) < 32'(GRID_SIDE));
    assign in_addr = AW'(32'(in_row) * GRID_SIDE + 32'(in_col));
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept = s_tvalid && s_tready;
    assign interior = (r_reg != '0) && (c_reg != '0) && (c_reg != LAST_COL);
    assign last_cell = (r_reg == LAST_ROW) && (c_reg == LAST_COL);
    assign out_load = (accept && (s_tuser != CMD_READ) && (s_tuser != CMD_STEP))
                    || (state_reg == S_RD)
                    || ((state_reg == S_B) && !interior && last_cell);

    assign east_val = $signed(cur_rdata);
    assign lap = 36'(north_reg) + 36'(south_reg) + 36'(west_reg) + 36'(east_val)
               - (36'(center_reg) <<< 2);
    assign s_val = 38'((p1_reg + 54'sd32768) >>> 16);
    assign t_val = 40'(s_val) + (40'(center_reg) <<< 1) - 40'(prevv_reg);
    assign n_val = 42'((p2_reg + 57'sd16384) >>> 15);
    always_comb
    begin
        if (n_val > 42'sh0007FFFFFFF)
            sat_val = 32'sh7FFFFFFF;
        else if (n_val < -42'sh00080000000)
            sat_val = -32'sh80000000;
        else
            sat_val = n_val[31:0];
    end

    always_comb
    begin
        cur_raddr = k_reg;
        cur_we = 1'b0;
        cur_waddr = k_reg;
        cur_wdata = '0;
        prev_we = 1'b0;
        prev_wdata = '0;
        line_we = 1'b0;
        line_wdata = center_reg;
        case (state_reg)
            S_CLR:
            begin
                cur_we = 1'b1;
                prev_we = 1'b1;
            end
            S_IDLE:
            begin
                cur_raddr = in_addr;
                cur_waddr = in_addr;
                cur_wdata = s_tdata[43:12];
                cur_we = accept && (s_tuser == CMD_WRITE) && in_inside;
            end
            S_B:
            begin
                cur_raddr = k_reg + ROW_STEP;
                line_we = !interior;
                line_wdata = cur_rdata;
            end
            S_C:
                cur_raddr = k_reg + AW'(1);
            S_WB:
            begin
                cur_we = 1'b1;
                cur_wdata = sat_val;
                prev_we = 1'b1;
                prev_wdata = center_reg;
                line_we = 1'b1;
            end
            default:
                cur_raddr = k_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
            cur_mem[cur_waddr] <= cur_wdata;
        if (prev_we)
            prev_mem[k_reg] <= prev_wdata;
        if (line_we)
            line_mem[c_reg] <= line_wdata;
        cur_rdata <= cur_mem[cur_raddr];
        prev_rdata <= prev_mem[k_reg];
        line_rdata <= line_mem[c_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            gain_reg <= GAIN_RESET;
            damp_reg <= DAMP_RESET;
            k_reg <= '0;
            r_reg <= '0;
            c_reg <= '0;
            out_valid_reg <= 1'b0;
            out_status_reg <= ST_WRITE;
            out_value_reg <= '0;
            rd_inside_reg <= 1'b0;
            center_reg <= '0;
            prevv_reg <= '0;
            north_reg <= '0;
            south_reg <= '0;
            west_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_GAIN)
                    gain_reg <= cfg_data[GAIN_W-1:0];
                else
                    damp_reg <= cfg_data[DAMP_W-1:0];
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    k_reg <= k_reg + AW'(1);
                    if (k_reg == LAST_CELL)
                    begin
                        k_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        out_value_reg <= '0;
                        case (s_tuser)
                            CMD_WRITE:
                                out_status_reg <= ST_WRITE;
                            CMD_READ:
                            begin
                                rd_inside_reg <= in_inside;
                                state_reg <= S_RD;
                            end
                            CMD_STEP:
                            begin
                                k_reg <= '0;
                                r_reg <= '0;
                                c_reg <= '0;
                                state_reg <= S_A;
                            end
                            default:
                                out_status_reg <= ST_BAD;
                        endcase
                    end
                end
                S_RD:
                begin
                    out_status_reg <= ST_READ;
                    out_value_reg <= rd_inside_reg ? cur_rdata : '0;
                    state_reg <= S_IDLE;
                end
                S_A:
                    state_reg <= S_B;
                S_B:
                begin
                    center_reg <= cur_rdata;
                    prevv_reg <= prev_rdata;
                    north_reg <= line_rdata;
                    if (interior)
                        state_reg <= S_C;
                    else
                    begin
                        west_reg <= cur_rdata;
                        k_reg <= k_reg + AW'(1);
                        if (c_reg == LAST_COL)
                        begin
                            c_reg <= '0;
                            r_reg <= r_reg + CW'(1);
                        end
                        else
                            c_reg <= c_reg + CW'(1);
                        if (last_cell)
                        begin
                            out_status_reg <= ST_STEP;
                            state_reg <= S_IDLE;
                        end
                        else
                            state_reg <= S_A;
                    end
                end
                S_C:
                begin
                    south_reg <= cur_rdata;
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    p1_reg <= 54'(lap * $signed({1'b0, gain_reg}));
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    p2_reg <= 57'(t_val * $signed({1'b0, damp_reg}));
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    west_reg <= center_reg;
                    k_reg <= k_reg + AW'(1);
                    c_reg <= c_reg + CW'(1);
                    state_reg <= S_A;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_value_reg;
    assign m_tuser = out_status_reg;

endmodule

FILE: rtl/wges_checker.sv
module wges_checker
    (
        input logic        clk,
        input logic        rst_n,
        input logic        s_tvalid,
        input logic        s_tready,
        input logic [1:0]  s_tuser,
        input logic        m_tvalid,
        input logic        m_tready,
        input logic [31:0] m_tdata,
        input logic [1:0]  m_tuser
    );

    import wges_pkg::*;

    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("Result word shown during reset.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result word changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_READ) |-> m_tdata == 32'd0)
        else $error("Non-read result carries data.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_WRITE) |=> m_tvalid && (m_tuser == ST_WRITE))
        else $error("Write word did not answer at once.");

endmodule

bind wave_grid_explicit_step wges_checker u_wges_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );
